[rtl/rgbcc_pkg.sv]
// Package for the RGB color correction pipeline: item types, register
// indexes, fixed-point constants and the pixel normalization table.
// No dependencies.
`default_nettype none

package rgbcc_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned DEFAULT_GAMMA_ENTRIES  = 1024;
  localparam int unsigned DEFAULT_GAIN_FRAC_BITS = 14;

  // Pixel values carry 12 fraction bits (1.0 = 4096)
  localparam int VAL_FRAC = 12;
  localparam int VAL_ONE  = 4096;
  localparam int VAL_HALF = 2048;
  localparam int PIX_MAX  = 255;

  // Luma weights 0.299 / 0.587 / 0.114 in Q.12, red first
  localparam logic [11:0] LUMA_W [3] = '{12'd1225, 12'd2404, 12'd467};

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] GAIN_RESET  = 16'd16384;
  localparam logic [15:0] BRIGHT_RESET = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgRedGain    = 3'd0,
    CfgGreenGain  = 3'd1,
    CfgBlueGain   = 3'd2,
    CfgSaturation = 3'd3,
    CfgBrightness = 3'd4,
    CfgContrast   = 3'd5,
    CfgGammaEn    = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OpPixel      = 1'b0,
    OpTableWrite = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [9:0]  entry_index;
    logic [7:0]  entry_value;
  } rgbcc_in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } rgbcc_out_item_t;

  // round(c * 4096 / 255) for every 8-bit code, built at elaboration
  typedef logic [12:0] norm_lut_t [256];

  function automatic norm_lut_t norm_lut_build();
    norm_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = 13'((i * VAL_ONE + 127) / PIX_MAX);
    end
    return lut;
  endfunction

  localparam norm_lut_t NORM_LUT = norm_lut_build();

endpackage

`default_nettype wire

[rtl/rgbcc_gamma_store.sv]
// Gamma table storage: one write port and three registered read ports,
// held as two copies of the table. Uses no package.
`default_nettype none

module rgbcc_gamma_store #(
  parameter int unsigned Entries = 1024,
  localparam int unsigned AddrW = $clog2(Entries)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AddrW-1:0]      waddr_i,
  input  wire logic [7:0]            wdata_i,
  input  wire logic                  re_i,
  input  wire logic [2:0][AddrW-1:0] raddr_i,
  output      logic [2:0][7:0]       rdata_o
);

  // Copy A serves red and green, copy B serves blue
  logic [7:0] mem_a_q [Entries];
  logic [7:0] mem_b_q [Entries];
  logic [2:0][7:0] rdata_q;

  // Both copies take every write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_a_q[waddr_i] <= wdata_i;
      mem_b_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q[0] <= mem_a_q[raddr_i[0]];
      rdata_q[1] <= mem_a_q[raddr_i[1]];
      rdata_q[2] <= mem_b_q[raddr_i[2]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/rgb_color_correction_pipeline.sv]
// RGB color correction pipeline top level: config registers, the
// arithmetic pipeline and the gamma lookup. Depends on rgbcc_pkg and
// rgbcc_gamma_store.
`default_nettype none

// One item enters per clock while the output is not stalled; table-write
// items take the same path as pixels and give no result. A pixel passes
// through a chain of registered multiplies (gain, luma, saturation,
// contrast, output scale) and the registered read of the gamma memory.
// A stalled output freezes the whole pipeline, and in_stall_o follows at
// once. A table write commits in the lookup stage, so pixels ahead of it
// see the old entry and pixels behind it see the new one. The gamma table
// has no reset; entries must be written before use. Configuration is to be
// written by the user while no item is in flight; the block does not enforce it.

module rgb_color_correction_pipeline
  import rgbcc_pkg::*;
#(
  parameter int unsigned GAMMA_ENTRIES  = DEFAULT_GAMMA_ENTRIES,
  parameter int unsigned GAIN_FRAC_BITS = DEFAULT_GAIN_FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire rgbcc_in_item_t        in_item_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      rgbcc_out_item_t       out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int F      = GAIN_FRAC_BITS;
  localparam int HALF_F = 1 << (F - 1);
  localparam int AW     = $clog2(GAMMA_ENTRIES);
  localparam int CH_W   = 30 - F;        // gained channel, unsigned
  localparam int LS_W   = CH_W + 14;     // luma products and sum
  localparam int M_W    = CH_W + 18;     // saturation product
  localparam int BT_W   = 30 - F;        // brightness term
  localparam int S2_W   = 50 - 2 * F;    // after saturation and brightness
  localparam int N_W    = S2_W + 18;     // contrast product
  localparam int S3_W   = N_W + 2 - F;   // after contrast
  localparam int BP_W   = S3_W + 10;     // bypass scale product
  localparam int IX_W   = 14 + AW;       // gamma index product
  localparam int NSTG   = 10;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [15:0]        red_gain_q, green_gain_q, blue_gain_q;
  logic [15:0]        sat_q, con_q;
  logic signed [15:0] bright_q;
  logic               gamma_en_q;
  logic signed [BT_W-1:0] bterm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_gain_q   <= GAIN_RESET;
      green_gain_q <= GAIN_RESET;
      blue_gain_q  <= GAIN_RESET;
      sat_q        <= GAIN_RESET;
      bright_q     <= BRIGHT_RESET;
      con_q        <= GAIN_RESET;
      gamma_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRedGain:    red_gain_q   <= cfg_wdata_i;
        CfgGreenGain:  green_gain_q <= cfg_wdata_i;
        CfgBlueGain:   blue_gain_q  <= cfg_wdata_i;
        CfgSaturation: sat_q        <= cfg_wdata_i;
        CfgBrightness: bright_q     <= cfg_wdata_i;
        CfgContrast:   con_q        <= cfg_wdata_i;
        CfgGammaEn:    gamma_en_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Brightness moved to the 12-bit value scale, round half up
  logic signed [29:0] bright_sh;
  assign bright_sh = ({{14{bright_q[15]}}, bright_q} <<< VAL_FRAC) + 30'(HALF_F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bterm_q <= '0;
    end else begin
      bterm_q <= BT_W'(bright_sh >>> F);
    end
  end

  logic [15:0] gain [3];
  assign gain[0] = red_gain_q;
  assign gain[1] = green_gain_q;
  assign gain[2] = blue_gain_q;

  // ---------------------------------------------------------------------
  // Pipeline control: one shared advance, valid bit per stage
  logic            adv;
  logic            out_valid_q;
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] wr_q;
  logic [9:0]      idx_q [NSTG-1];
  logic [7:0]      val_q [NSTG-1];

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // Item kind and table-write fields follow the item down to the lookup
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_q     <= {wr_q[NSTG-2:0], in_item_i.opcode == OpTableWrite};
      idx_q[0] <= in_item_i.entry_index;
      val_q[0] <= in_item_i.entry_value;
      for (int i = 1; i < NSTG - 1; i++) begin
        idx_q[i] <= idx_q[i-1];
        val_q[i] <= val_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath signals, one lane per color
  logic [7:0]              pix       [3];
  logic [12:0]             s1_v_q    [3];
  logic [29:0]             ch_prod   [3];
  logic [CH_W-1:0]         s2_ch_q   [3];
  logic [LS_W-1:0]         s3_lp_q   [3];
  logic [CH_W-1:0]         s3_ch_q   [3];
  logic [LS_W-1:0]         luma_sum;
  logic [CH_W-1:0]         s4_ch_q   [3];
  logic [CH_W-1:0]         s4_gray_q;
  logic signed [CH_W:0]    diff      [3];
  logic signed [M_W-1:0]   s5_m_q    [3];
  logic [CH_W-1:0]         s5_gray_q;
  logic signed [M_W:0]     m_rnd     [3];
  logic signed [S2_W-1:0]  s6_t_q    [3];
  logic signed [S2_W:0]    t_mid     [3];
  logic signed [N_W-1:0]   s7_n_q    [3];
  logic signed [N_W:0]     n_rnd     [3];
  logic signed [S3_W-1:0]  s8_t_q    [3];
  logic [12:0]             clamped   [3];
  logic [IX_W-1:0]         s9_ix_q   [3];
  logic signed [BP_W-1:0]  s9_bp_q   [3];
  logic [IX_W-1:0]         ix_rnd    [3];
  logic signed [BP_W:0]    bp_rnd    [3];
  logic [7:0]              byp_d     [3];
  logic [7:0]              s10_byp_q [3];
  logic [2:0][AW-1:0]      rd_addr;
  logic [2:0][7:0]         rd_data;

  assign pix[0] = in_item_i.in_red;
  assign pix[1] = in_item_i.in_green;
  assign pix[2] = in_item_i.in_blue;

  // Gain product and luma sum
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ch_prod[k] = 30'(s1_v_q[k]) * 30'(gain[k]) + 30'(HALF_F);
    end
    luma_sum = s3_lp_q[0] + s3_lp_q[1] + s3_lp_q[2] + LS_W'(VAL_HALF);
  end

  // Saturation difference, rounding and contrast offset
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = $signed({1'b0, s4_ch_q[k]}) - $signed({1'b0, s4_gray_q});
      m_rnd[k] = ((M_W+1)'(s5_m_q[k]) + (M_W+1)'(HALF_F)) >>> F;
      t_mid[k] = (S2_W+1)'(s6_t_q[k]) - (S2_W+1)'(VAL_HALF);
      n_rnd[k] = ((N_W+1)'(s7_n_q[k]) + (N_W+1)'(HALF_F)) >>> F;
    end
  end

  // Output scaling: clamp for the table index, saturate for bypass
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s8_t_q[k][S3_W-1]) begin
        clamped[k] = '0;
      end else if (s8_t_q[k] > S3_W'(VAL_ONE)) begin
        clamped[k] = 13'(VAL_ONE);
      end else begin
        clamped[k] = s8_t_q[k][12:0];
      end
      ix_rnd[k]  = (s9_ix_q[k] + IX_W'(VAL_HALF)) >> VAL_FRAC;
      rd_addr[k] = AW'(ix_rnd[k]);
      bp_rnd[k]  = ((BP_W+1)'(s9_bp_q[k]) + (BP_W+1)'(VAL_HALF)) >>> VAL_FRAC;
      if (bp_rnd[k][BP_W]) begin
        byp_d[k] = '0;
      end else if (bp_rnd[k] > (BP_W+1)'(PIX_MAX)) begin
        byp_d[k] = 8'(PIX_MAX);
      end else begin
        byp_d[k] = bp_rnd[k][7:0];
      end
    end
  end

  // Pipeline registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        // normalize to Q.12
        s1_v_q[k]    <= NORM_LUT[pix[k]];
        // channel gain
        s2_ch_q[k]   <= CH_W'(ch_prod[k] >> F);
        // weighted luma terms
        s3_lp_q[k]   <= LS_W'(s2_ch_q[k]) * LS_W'(LUMA_W[k]);
        s3_ch_q[k]   <= s2_ch_q[k];
        s4_ch_q[k]   <= s3_ch_q[k];
        // distance from luma times saturation
        s5_m_q[k]    <= M_W'(diff[k]) * M_W'($signed({1'b0, sat_q}));
        // back to luma, plus brightness
        s6_t_q[k]    <= S2_W'(m_rnd[k]) + S2_W'($signed({1'b0, s5_gray_q}))
                        + S2_W'(bterm_q);
        // contrast about mid grey
        s7_n_q[k]    <= N_W'(t_mid[k]) * N_W'($signed({1'b0, con_q}));
        s8_t_q[k]    <= S3_W'(n_rnd[k]) + S3_W'(VAL_HALF);
        // table index and bypass products
        s9_ix_q[k]   <= IX_W'(clamped[k]) * IX_W'(GAMMA_ENTRIES - 1);
        s9_bp_q[k]   <= BP_W'(s8_t_q[k]) * BP_W'(PIX_MAX);
        s10_byp_q[k] <= byp_d[k];
      end
      s4_gray_q <= CH_W'(luma_sum >> VAL_FRAC);
      s5_gray_q <= s4_gray_q;
    end
  end

  // ---------------------------------------------------------------------
  // Gamma table: writes and reads both happen in the lookup stage
  logic tbl_we;
  assign tbl_we = adv && vld_q[NSTG-2] && wr_q[NSTG-2]
                  && (32'(idx_q[NSTG-2]) < GAMMA_ENTRIES);

  rgbcc_gamma_store #(
    .Entries (GAMMA_ENTRIES)
  ) u_gamma_store (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(idx_q[NSTG-2])),
    .wdata_i (val_q[NSTG-2]),
    .re_i    (adv),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------------
  // Output register: only pixel items produce a result
  rgbcc_out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[NSTG-1] && !wr_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q.out_red   <= gamma_en_q ? rd_data[0] : s10_byp_q[0];
      out_item_q.out_green <= gamma_en_q ? rd_data[1] : s10_byp_q[1];
      out_item_q.out_blue  <= gamma_en_q ? rd_data[2] : s10_byp_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

[bench/rgb_color_correction_pipeline_tb.sv]
// Self-checking bench for rgb_color_correction_pipeline: a scoreboard class predicts
// every corrected pixel in fixed point, and plain tasks drive items and config writes.
// Depends on rgbcc_pkg and the pipeline RTL.
`timescale 1ns / 100ps

module rgb_color_correction_pipeline_tb;
  import rgbcc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned PHASE_ITEMS    = 29;
  localparam int unsigned GAMMA_DEPTH    = DEFAULT_GAMMA_ENTRIES;

  // Predicts corrected pixels and checks them in order
  class pixel_scoreboard;
    longint gain [3];
    longint sat_factor;
    longint offset;
    longint contrast_factor;
    bit gamma_on;
    logic [7:0] gamma_lut [GAMMA_DEPTH];
    rgbcc_out_item_t expected_pixels [$];
    int unsigned errors;

    function new();
      gain = '{16384, 16384, 16384};
      sat_factor = 16384;
      offset = 0;
      contrast_factor = 16384;
      gamma_on = 1'b0;
      errors = 0;
    endfunction

    // floor(v / 2^s + 1/2), arithmetic shift keeps negatives right
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Gamma lookup, or scale to 0..255 with saturation
    function logic [7:0] finish_channel(longint v);
      longint c;
      longint idx;
      longint o;
      if (gamma_on) begin
        c = (v < 0) ? 0 : ((v > VAL_ONE) ? VAL_ONE : v);
        idx = (c * (longint'(GAMMA_DEPTH) - 1) + VAL_HALF) >>> VAL_FRAC;
        return gamma_lut[idx];
      end
      o = round_shift(v * PIX_MAX, VAL_FRAC);
      if (o < 0) o = 0;
      if (o > PIX_MAX) o = PIX_MAX;
      return o[7:0];
    endfunction

    function rgbcc_out_item_t correct_pixel(rgbcc_in_item_t it);
      longint ch [3];
      logic [7:0] pix [3];
      logic [7:0] res [3];
      longint norm;
      longint luma;
      longint t;
      rgbcc_out_item_t r;
      pix = '{it.in_red, it.in_green, it.in_blue};
      // normalize to Q.12 and apply per-channel gain
      for (int k = 0; k < 3; k++) begin
        norm = (longint'(pix[k]) * VAL_ONE + 127) / PIX_MAX;
        ch[k] = round_shift(norm * gain[k], DEFAULT_GAIN_FRAC_BITS);
      end
      luma = round_shift(longint'(LUMA_W[0]) * ch[0] + longint'(LUMA_W[1]) * ch[1] +
                         longint'(LUMA_W[2]) * ch[2], VAL_FRAC);
      // saturation, brightness, contrast about mid grey
      for (int k = 0; k < 3; k++) begin
        t = luma + round_shift((ch[k] - luma) * sat_factor, DEFAULT_GAIN_FRAC_BITS);
        t = round_shift(t * (longint'(1) <<< DEFAULT_GAIN_FRAC_BITS) + offset * VAL_ONE,
                        DEFAULT_GAIN_FRAC_BITS);
        t = round_shift((t - VAL_HALF) * contrast_factor, DEFAULT_GAIN_FRAC_BITS) + VAL_HALF;
        res[k] = finish_channel(t);
      end
      r.out_red   = res[0];
      r.out_green = res[1];
      r.out_blue  = res[2];
      return r;
    endfunction

    function void set_register(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CfgRedGain:    gain[0] = longint'(data);
        CfgGreenGain:  gain[1] = longint'(data);
        CfgBlueGain:   gain[2] = longint'(data);
        CfgSaturation: sat_factor = longint'(data);
        CfgBrightness: offset = longint'(signed'(data));
        CfgContrast:   contrast_factor = longint'(data);
        CfgGammaEn:    gamma_on = data[0];
        default: ;
      endcase
    endfunction

    // Table writes commit in order with pixels, so update at accept time
    function void note_input(rgbcc_in_item_t it);
      if (it.opcode == OpTableWrite) begin
        if (it.entry_index < GAMMA_DEPTH) gamma_lut[it.entry_index] = it.entry_value;
      end else begin
        expected_pixels.push_back(correct_pixel(it));
      end
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(rgbcc_out_item_t got);
      rgbcc_out_item_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("out_red", want.out_red, got.out_red);
      compare_field("out_green", want.out_green, got.out_green);
      compare_field("out_blue", want.out_blue, got.out_blue);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  rgbcc_in_item_t        in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rgbcc_out_item_t       out_item_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  bit input_gaps = 1'b0;
  bit stall_bursts = 1'b0;
  int unsigned idle_cycles = 0;
  pixel_scoreboard sb;

  rgb_color_correction_pipeline dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Output side: random stall bursts
  initial forever begin
    @(posedge clk_i);
    if (stall_bursts && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgbcc_in_item_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rgbcc_in_item_t it;
    it.opcode      = OpPixel;
    it.in_red      = r;
    it.in_green    = g;
    it.in_blue     = b;
    it.entry_index = 10'($urandom);
    it.entry_value = 8'($urandom);
    return it;
  endfunction

  function automatic rgbcc_in_item_t make_write(int unsigned idx, logic [7:0] value);
    rgbcc_in_item_t it;
    it.opcode      = OpTableWrite;
    it.in_red      = 8'($urandom);
    it.in_green    = 8'($urandom);
    it.in_blue     = 8'($urandom);
    it.entry_index = 10'(idx);
    it.entry_value = value;
    return it;
  endfunction

  // Q2.14 factor: half near unity, half anywhere
  function automatic logic [15:0] rand_factor();
    if ($urandom_range(0, 1)) return 16'($urandom_range(8192, 24576));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] rand_offset();
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 4096) - 2048);
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_item(input rgbcc_in_item_t it);
    if (input_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  // Table writes give no result, so wait out the pipeline after the last pixel
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  task automatic apply_settings(input logic [15:0] rg, gg, bg, sat, br, con,
                                input logic gam);
    write_reg(CfgRedGain, rg);
    write_reg(CfgGreenGain, gg);
    write_reg(CfgBlueGain, bg);
    write_reg(CfgSaturation, sat);
    write_reg(CfgBrightness, br);
    write_reg(CfgContrast, con);
    write_reg(CfgGammaEn, {15'd0, gam});
    cfg_we_i <= 1'b0;
  endtask

  // Mostly pixels, with table rewrites mixed in
  task automatic run_phase(input int unsigned n, input bit gaps);
    input_gaps   = gaps;
    stall_bursts = gaps;
    repeat (n) begin
      if ($urandom_range(0, 5) == 0)
        send_item(make_write($urandom_range(0, GAMMA_DEPTH - 1), 8'($urandom_range(0, 255))));
      else
        send_item(make_pixel(rand_channel(), rand_channel(), rand_channel()));
    end
    drain_pipeline();
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner pixels at reset settings, gamma bypassed
    input_gaps   = 1'b1;
    stall_bursts = 1'b1;
    send_item(make_pixel(8'd0, 8'd0, 8'd0));
    send_item(make_pixel(8'd255, 8'd255, 8'd255));
    send_item(make_pixel(8'd255, 8'd0, 8'd0));
    send_item(make_pixel(8'd0, 8'd255, 8'd0));
    send_item(make_pixel(8'd0, 8'd0, 8'd255));
    send_item(make_pixel(8'd128, 8'd128, 8'd128));
    send_item(make_pixel(8'd1, 8'd254, 8'd127));
    send_item(make_pixel(8'd170, 8'd85, 8'd170));
    send_item(make_write(0, 8'd0));
    send_item(make_write(GAMMA_DEPTH - 1, 8'd255));
    drain_pipeline();

    // Fill the whole gamma table before it is ever enabled
    input_gaps = 1'($urandom_range(0, 1));
    for (int i = 0; i < GAMMA_DEPTH; i++) send_item(make_write(i, 8'($urandom_range(0, 255))));
    drain_pipeline();

    // Extreme settings, bypass then gamma
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b0);
    run_phase(PHASE_ITEMS, 1'b1);
    apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
    run_phase(PHASE_ITEMS, 1'b1);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b1);
    run_phase(PHASE_ITEMS, 1'b1);
    apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1);
    run_phase(PHASE_ITEMS, 1'b1);
    // Unity gains, no saturation: grey output through the table
    apply_settings(16'd16384, 16'd16384, 16'd16384, 16'd0, 16'd0, 16'd16384, 1'b1);
    run_phase(PHASE_ITEMS, 1'b0);

    // Random settings; the last two phases run without idling
    for (int p = 0; p < 6; p++) begin
      apply_settings(rand_factor(), rand_factor(), rand_factor(), rand_factor(),
                     rand_offset(), rand_factor(), 1'($urandom_range(0, 1)));
      run_phase(PHASE_ITEMS, (p < 4) && ($urandom_range(0, 3) != 0));
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
